// File: rtl/sgl_rs_pkg.sv
package sgl_rs_pkg;

   // Widths of the fields on the stream ports.
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 32;
   localparam int OFS_W    = 32;
   localparam int SECT_W   = 23;
   localparam int OCOUNT_W = 9;

   // Packed tdata widths, rounded up to whole bytes.
   localparam int REQ_FIELDS_W = OFS_W + SECT_W + ADDR_W + LEN_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ADDR_W + LEN_W + OCOUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SKIP,
      PH_EMIT,
      PH_DONE
   } phase_type;

   // One source descriptor after the intake stage; the sector count is
   // already turned into a byte total.
   typedef struct packed {
      logic              start;
      logic [OFS_W-1:0]  skip_bytes;
      logic [LEN_W-1:0]  byte_total;
      logic [ADDR_W-1:0] desc_addr;
      logic [LEN_W-1:0]  desc_len;
      logic              list_end;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   out_addr;
      logic [LEN_W-1:0]    out_len;
      logic                out_last;
      logic [OCOUNT_W-1:0] out_count;
      logic                overrun;
   } result_type;

endpackage

// File: rtl/sgl_rs_intake.sv
module sgl_rs_intake #(
   parameter int SECTOR_BYTES = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic                                 in_start,
   input  logic [sgl_rs_pkg::OFS_W-1:0]         in_skip_bytes,
   input  logic [sgl_rs_pkg::SECT_W-1:0]        in_sector_count,
   input  logic [sgl_rs_pkg::ADDR_W-1:0]        in_desc_addr,
   input  logic [sgl_rs_pkg::LEN_W-1:0]         in_desc_len,
   input  logic                                 in_list_end,
   output logic                                 item_valid,
   input  logic                                 item_ready,
   output sgl_rs_pkg::item_type                 item
);
   import sgl_rs_pkg::*;

   localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
   localparam int PROD_W = SECT_W + SB_W;

   logic             valid_ff, valid_in;
   item_type         item_ff, item_in;
   logic             load;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W+LEN_W-1:0] prod_wide;

   // Byte total of the request, taken modulo 2^32.
   assign prod      = PROD_W'(in_sector_count) * PROD_W'(SECTOR_BYTES);
   assign prod_wide = {{LEN_W{1'b0}}, prod};

   assign in_ready = !valid_ff || item_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      item_in             = item_ff;
      item_in.start       = in_start;
      item_in.skip_bytes  = in_skip_bytes;
      item_in.byte_total  = prod_wide[LEN_W-1:0];
      item_in.desc_addr   = in_desc_addr;
      item_in.desc_len    = in_desc_len;
      item_in.list_end    = in_list_end;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/sgl_rs_slicer.sv
module sgl_rs_slicer #(
   parameter int MAX_DESCRIPTORS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  sgl_rs_pkg::item_type   item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sgl_rs_pkg::result_type rsp
);
   import sgl_rs_pkg::*;

   localparam int CNT_W = $clog2(MAX_DESCRIPTORS + 1);

   phase_type         phase_ff, phase_in, phase_cur;
   logic [OFS_W-1:0]  offset_ff, offset_in, offset_cur;
   logic [LEN_W-1:0]  bytes_ff, bytes_in, bytes_cur;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_cur, cnt_next;
   logic [CNT_W+OCOUNT_W-1:0] cnt_wide;
   logic              rsp_v_ff, rsp_v_in;
   result_type        rsp_ff, rsp_in;
   logic              fire, produce;
   logic [OFS_W-1:0]  base;
   logic [LEN_W-1:0]  avail;
   logic [ADDR_W-1:0] piece_addr;
   logic              skip_whole, fits, at_limit;

   assign item_ready = !rsp_v_ff || rsp_ready;
   assign fire       = item_valid && item_ready;

   // A start beat restarts the request with its own offset and total.
   assign phase_cur  = item.start ? PH_SKIP : phase_ff;
   assign offset_cur = item.start ? item.skip_bytes : offset_ff;
   assign bytes_cur  = item.start ? item.byte_total : bytes_ff;
   assign cnt_cur    = item.start ? '0 : cnt_ff;
   assign cnt_next   = cnt_cur + CNT_W'(1);
   assign cnt_wide   = {{OCOUNT_W{1'b0}}, cnt_next};
   assign at_limit   = (cnt_next == CNT_W'(MAX_DESCRIPTORS));

   // The offset only trims the descriptor that holds it.
   assign base       = (phase_cur == PH_SKIP) ? offset_cur : '0;
   assign skip_whole = offset_cur >= item.desc_len;
   assign avail      = item.desc_len - base;
   assign piece_addr = item.desc_addr + base;
   assign fits       = {1'b0, item.desc_len} >= ({1'b0, base} + {1'b0, bytes_cur});

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      bytes_in  = bytes_ff;
      cnt_in    = cnt_ff;
      produce   = 1'b0;
      rsp_in    = rsp_ff;
      if (fire) begin
         phase_in  = phase_cur;
         offset_in = offset_cur;
         bytes_in  = bytes_cur;
         cnt_in    = cnt_cur;
         unique case (phase_cur)
            PH_SKIP, PH_EMIT: begin
               if (phase_cur == PH_SKIP && skip_whole) begin
                  offset_in = offset_cur - item.desc_len;
                  if (item.list_end) begin
                     produce          = 1'b1;
                     rsp_in.out_addr  = '0;
                     rsp_in.out_len   = '0;
                     rsp_in.out_last  = 1'b1;
                     rsp_in.out_count = '0;
                     rsp_in.overrun   = 1'b1;
                     phase_in         = PH_DONE;
                  end
               end else begin
                  produce          = 1'b1;
                  offset_in        = '0;
                  cnt_in           = cnt_next;
                  rsp_in.out_addr  = piece_addr;
                  rsp_in.out_count = cnt_wide[OCOUNT_W-1:0];
                  if (fits) begin
                     rsp_in.out_len  = bytes_cur;
                     rsp_in.out_last = 1'b1;
                     rsp_in.overrun  = 1'b0;
                     bytes_in        = '0;
                     phase_in        = PH_DONE;
                  end else begin
                     rsp_in.out_len = avail;
                     bytes_in       = bytes_cur - avail;
                     if (item.list_end || at_limit) begin
                        rsp_in.out_last = 1'b1;
                        rsp_in.overrun  = 1'b1;
                        phase_in        = PH_DONE;
                     end else begin
                        rsp_in.out_last = 1'b0;
                        rsp_in.overrun  = 1'b0;
                        phase_in        = PH_EMIT;
                     end
                  end
               end
            end
            PH_IDLE, PH_DONE: begin
               produce = 1'b0;
            end
            default: begin
               produce = 1'b0;
            end
         endcase
      end
      if (fire) begin
         rsp_v_in = produce;
      end else if (rsp_ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         offset_ff <= '0;
         bytes_ff  <= '0;
         cnt_ff    <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         bytes_ff  <= bytes_in;
         cnt_ff    <= cnt_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp       = rsp_ff;

   // An overrun always closes the list.
   a_overrun_last: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.overrun |-> rsp_ff.out_last)
      else $error("overrun result not marked last");

   // A normal result always counts at least itself.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_ff.overrun |-> rsp_ff.out_count != '0)
      else $error("normal result with zero count");

   // Beats outside a request leave nothing behind.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      fire && !item.start && (phase_ff == PH_IDLE || phase_ff == PH_DONE)
      |=> !rsp_v_ff)
      else $error("result produced outside a request");

   // The running count never passes the descriptor limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DESCRIPTORS))
      else $error("descriptor count past limit");

   // Done means the range was closed with a result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff != PH_DONE && phase_in == PH_DONE |=> rsp_v_ff)
      else $error("request finished without a result");

endmodule

// File: rtl/sgl_range_slicer_top.sv
// Each accepted source descriptor beat is held in the intake register, and its result beat is
// then held in the slicer output register. Throughput: one descriptor beat per cycle while
// no result waits on rsp_tready, set by the single pass through the slicer stage.
// Descriptors outside a request, and skipped ones that do not end the list, give no beat.
// Reset is synchronous and active high; it clears the request state and both valid flags.
// After reset no request is active until a beat with the start flag arrives.
module sgl_range_slicer_top #(
   parameter int SECTOR_BYTES    = 512,
   parameter int MAX_DESCRIPTORS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // Source descriptor channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: skip_bytes, sector_count, desc_addr, desc_len, zero pad.
   input  logic [sgl_rs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Fields from bit 0: start_req.
   input  logic                               req_tuser,
   // Marks the final descriptor of the source list.
   input  logic                               req_tlast,
   // Sliced descriptor channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: out_addr, out_len, out_count, zero pad.
   output logic [sgl_rs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Fields from bit 0: overrun.
   output logic                               rsp_tuser,
   // Marks the final descriptor of the new list.
   output logic                               rsp_tlast
);
   import sgl_rs_pkg::*;

   // Bit positions of the request fields inside req_tdata.
   localparam int OFS_LO  = 0;
   localparam int SECT_LO = OFS_LO + OFS_W;
   localparam int ADDR_LO = SECT_LO + SECT_W;
   localparam int LEN_LO  = ADDR_LO + ADDR_W;

   logic       item_valid, item_ready;
   item_type   item;
   result_type rsp;

   // The intake stage registers each beat and turns the sector count into a
   // byte total, so the slicer stage does no multiply.
   sgl_rs_intake #(
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_intake (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_start        (req_tuser),
      .in_skip_bytes   (req_tdata[OFS_LO +: OFS_W]),
      .in_sector_count (req_tdata[SECT_LO +: SECT_W]),
      .in_desc_addr    (req_tdata[ADDR_LO +: ADDR_W]),
      .in_desc_len     (req_tdata[LEN_LO +: LEN_W]),
      .in_list_end     (req_tlast),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   // The slicer keeps the running offset, the bytes still wanted and the
   // descriptor count, and writes at most one result per descriptor into
   // its output register. While that register waits on the consumer, the
   // intake stage can hold one more beat and then stalls the source.
   sgl_rs_slicer #(
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_slicer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}},
                       rsp.out_count, rsp.out_len, rsp.out_addr};
   assign rsp_tuser = rsp.overrun;
   assign rsp_tlast = rsp.out_last;

endmodule

// File: verif/sgl_range_slicer_top_test.sv
`timescale 1ns / 1ps

module sgl_range_slicer_top_test;
   import sgl_rs_pkg::*;

   // The block is built with its default geometry, and the slice tracker
   // below uses the same numbers.
   localparam int SECTOR_BYTES    = 512;
   localparam int MAX_DESCRIPTORS = 256;

   // No new random request starts once this many beats have been sent.
   localparam int RANDOM_BEATS = 1650;

   // How a directed row is checked: against the slice tracker, against an
   // expectation typed into the row, or as a beat that must give no result.
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_TYPED,
      CHK_NONE
   } check_kind_type;

   // One source descriptor beat with its fields unpacked.
   typedef struct packed {
      logic              start;
      logic [OFS_W-1:0]  skip_bytes;
      logic [SECT_W-1:0] sector_count;
      logic [ADDR_W-1:0] desc_addr;
      logic [LEN_W-1:0]  desc_len;
      logic              list_end;
   } desc_item_type;

   typedef struct packed {
      desc_item_type  d;
      check_kind_type chk;
      result_type     exp;
   } dir_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // Idle and stall odds in percent, changed as the random part moves on.
   int sender_idle_pct = 0;
   int stall_pct       = 0;

   int mismatch_count = 0;
   int sent_beats     = 0;

   // Sliced descriptors that the block still owes us, oldest first.
   result_type pending_slices [$];

   // Request state as the slice tracker sees it.
   phase_type         cur_phase     = PH_IDLE;
   logic [OFS_W-1:0]  ofs_remaining = '0;
   logic [LEN_W-1:0]  bytes_wanted  = '0;
   int                slices_sent   = 0;

   // Directed beats. Rows whose result is plain from the row itself carry it;
   // the chained requests in the middle are left to the slice tracker.
   dir_row_type directed_rows [0:20] = '{
      // A descriptor right after reset belongs to no request.
      '{'{1'b0, 32'h0, 23'h0, 32'h0000_1234, 32'h10, 1'b0}, CHK_NONE, '0},
      // Zero sectors: the offset descriptor comes out empty and last.
      '{'{1'b1, 32'h0, 23'h0, 32'h0000_A000, 32'h200, 1'b0}, CHK_TYPED,
        '{32'h0000_A000, 32'h0, 1'b1, 9'd1, 1'b0}},
      // The list ends while the offset is still being skipped.
      '{'{1'b1, 32'hFFFF_FFFF, 23'h1, 32'h5, 32'h10, 1'b1}, CHK_TYPED,
        '{32'h0, 32'h0, 1'b1, 9'd0, 1'b1}},
      // The trimmed address wraps around the top of the address space.
      '{'{1'b1, 32'h5, 23'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, CHK_TYPED,
        '{32'h4, 32'h200, 1'b1, 9'd1, 1'b0}},
      // After the range is done, even a list end gives nothing.
      '{'{1'b0, 32'h0, 23'h0, 32'h0, 32'h0, 1'b1}, CHK_NONE, '0},
      // A request that skips one whole descriptor, trims the next, passes an
      // empty one and cuts the fourth.
      '{'{1'b1, 32'd100, 23'd2, 32'h1000, 32'd50, 1'b0}, CHK_NONE, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'h2000, 32'd100, 1'b0}, CHK_MODEL, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'h3000, 32'd0, 1'b0}, CHK_MODEL, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'h4000, 32'd2000, 1'b0}, CHK_MODEL, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'h5000, 32'd7, 1'b1}, CHK_NONE, '0},
      // Largest sector count, completed by a full-size descriptor.
      '{'{1'b1, 32'h0, 23'h7F_FFFF, 32'h0, 32'h10, 1'b0}, CHK_MODEL, '0},
      '{'{1'b0, 32'hFFFF_FFFF, 23'h7F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
        CHK_MODEL, '0},
      // The list runs out in the middle of the range.
      '{'{1'b1, 32'h10, 23'h7F_FFFF, 32'h8000, 32'h20, 1'b0}, CHK_MODEL, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'h9000, 32'h40, 1'b1}, CHK_TYPED,
        '{32'h9000, 32'h40, 1'b1, 9'd2, 1'b1}},
      // A new start abandons the request that is still emitting.
      '{'{1'b1, 32'h0, 23'd4, 32'h100, 32'h10, 1'b0}, CHK_MODEL, '0},
      '{'{1'b1, 32'd3, 23'd1, 32'h200, 32'h400, 1'b1}, CHK_MODEL, '0},
      // Offset equal to the first length, then the range ends with the list.
      '{'{1'b1, 32'h400, 23'd1, 32'hC000, 32'h400, 1'b0}, CHK_NONE, '0},
      '{'{1'b0, 32'h0, 23'h0, 32'hD000, 32'h200, 1'b1}, CHK_MODEL, '0},
      // Alternating bit patterns on the offset, sector count and address fields.
      '{'{1'b1, 32'hAAAA_AAAA, 23'h55_5555, 32'h5555_5555, 32'hAAAA_AAAB, 1'b1},
        CHK_MODEL, '0},
      // The list ends exactly where the offset does.
      '{'{1'b1, 32'd1, 23'd0, 32'h0, 32'd1, 1'b1}, CHK_TYPED,
        '{32'h0, 32'h0, 1'b1, 9'd0, 1'b1}},
      '{'{1'b0, 32'h0, 23'h0, 32'h0, 32'd5, 1'b0}, CHK_NONE, '0}
   };

   sgl_range_slicer_top #(
      .SECTOR_BYTES    (SECTOR_BYTES),
      .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Slice tracker: advances the request state by one source descriptor and
   // returns 1 when that descriptor yields a sliced descriptor.
   function automatic bit slice_descriptor(input desc_item_type d, output result_type res);
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  avail;
      res = '0;
      if (d.start) begin
         ofs_remaining = d.skip_bytes;
         bytes_wanted  = d.sector_count * 32'(SECTOR_BYTES);
         slices_sent   = 0;
         cur_phase     = PH_SKIP;
      end
      if (cur_phase == PH_SKIP) begin
         if (ofs_remaining >= d.desc_len) begin
            // The whole descriptor lies before the offset.
            ofs_remaining = ofs_remaining - d.desc_len;
            if (d.list_end) begin
               res.out_last = 1'b1;
               res.overrun  = 1'b1;
               cur_phase    = PH_DONE;
               return 1'b1;
            end
            return 1'b0;
         end
         base          = d.desc_addr + ofs_remaining;
         avail         = d.desc_len - ofs_remaining;
         ofs_remaining = '0;
      end else if (cur_phase == PH_EMIT) begin
         base  = d.desc_addr;
         avail = d.desc_len;
      end else begin
         return 1'b0;
      end
      slices_sent++;
      res.out_addr  = base;
      res.out_count = slices_sent[OCOUNT_W-1:0];
      if (avail >= bytes_wanted) begin
         res.out_len  = bytes_wanted;
         res.out_last = 1'b1;
         bytes_wanted = '0;
         cur_phase    = PH_DONE;
      end else begin
         bytes_wanted = bytes_wanted - avail;
         res.out_len  = avail;
         if (d.list_end || slices_sent >= MAX_DESCRIPTORS) begin
            res.out_last = 1'b1;
            res.overrun  = 1'b1;
            cur_phase    = PH_DONE;
         end else begin
            cur_phase = PH_EMIT;
         end
      end
      return 1'b1;
   endfunction

   // Offers one descriptor beat, after a random number of idle cycles, and
   // books the expected result once the beat is taken. It returns at the
   // edge that took the beat, so the next call drives valid only once there.
   task automatic send_descriptor(input desc_item_type d, input check_kind_type chk,
                                  input result_type typed);
      result_type slice;
      bit         produced;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({d.desc_len, d.desc_addr, d.sector_count, d.skip_bytes});
      req_tuser  <= d.start;
      req_tlast  <= d.list_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_beats++;
      produced = slice_descriptor(d, slice);
      if (chk == CHK_TYPED)
         pending_slices.push_back(typed);
      else if (chk == CHK_MODEL && produced)
         pending_slices.push_back(slice);
   endtask

   // One random request. Most are well formed with random lengths, offsets
   // and counts; some run the list short, point past its end, get abandoned
   // by the next start, or are pure noise. Every so often a long chain of
   // tiny descriptors runs into the descriptor limit.
   task automatic run_request(input int req_no);
      int unsigned lens [0:MAX_DESCRIPTORS+7];
      int unsigned total, ofs, secs, n, sent, kind;
      bit          chain, noise, cut;
      desc_item_type d;
      kind  = $urandom_range(99);
      chain = (req_no % 200 == 50);
      noise = !chain && kind >= 93;
      cut   = !chain && kind >= 85 && kind < 93;
      n     = chain ? $urandom_range(MAX_DESCRIPTORS, MAX_DESCRIPTORS + 6)
                    : $urandom_range(1, 8);
      total = 0;
      for (int i = 0; i < n; i++) begin
         if (chain)
            lens[i] = $urandom_range(1, 16);
         else if ($urandom_range(3) == 0)
            lens[i] = $urandom_range(0, 3);
         else
            lens[i] = $urandom_range(0, 3000);
         total += lens[i];
      end
      ofs = chain ? $urandom_range(0, lens[0] - 1) : $urandom_range(0, total);
      if (chain) begin
         // Far more bytes than the chain holds, so the limit ends it.
         secs = $urandom_range(100, 23'h7F_FFFF);
      end else if (kind < 60 || cut) begin
         secs = $urandom_range(0, (total - ofs) / SECTOR_BYTES);
      end else if (kind < 75) begin
         secs = (total - ofs) / SECTOR_BYTES + $urandom_range(1, 20);
      end else begin
         ofs  = total + $urandom_range(0, 600);
         secs = $urandom_range(0, 50);
      end
      sent = cut ? $urandom_range(1, n) : n;
      for (int i = 0; i < sent; i++) begin
         // Offset and count are don't-care after the first beat; they still
         // carry random bits.
         d.start        = (i == 0);
         d.skip_bytes   = (i == 0) ? ofs : $urandom;
         d.sector_count = (i == 0) ? SECT_W'(secs)
                                   : SECT_W'($urandom_range(0, 23'h7F_FFFF));
         d.desc_addr    = $urandom;
         d.desc_len     = lens[i];
         d.list_end     = !cut && (i == n - 1);
         if (noise) begin
            d.start        = 1'($urandom_range(1));
            d.skip_bytes   = $urandom;
            d.sector_count = SECT_W'($urandom_range(0, 23'h7F_FFFF));
            d.desc_len     = $urandom;
            d.list_end     = 1'($urandom_range(1));
         end
         send_descriptor(d, CHK_MODEL, '0);
      end
   endtask

   // Result side: checks each accepted beat against the oldest expectation,
   // then picks the next ready value. Sampling and driving at the same edge
   // keeps the check on the values that the edge acted on.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.out_addr  = rsp_tdata[ADDR_W-1:0];
         got.out_len   = rsp_tdata[ADDR_W +: LEN_W];
         got.out_count = rsp_tdata[ADDR_W+LEN_W +: OCOUNT_W];
         got.out_last  = rsp_tlast;
         got.overrun   = rsp_tuser;
         if (pending_slices.size() == 0) begin
            $display("%0t: unexpected beat addr %h len %h last %b count %0d overrun %b",
                     $time, got.out_addr, got.out_len, got.out_last, got.out_count,
                     got.overrun);
            mismatch_count++;
         end else begin
            want = pending_slices.pop_front();
            if (got.out_addr !== want.out_addr) begin
               $display("%0t: out_addr expected %h, got %h", $time, want.out_addr,
                        got.out_addr);
               mismatch_count++;
            end
            if (got.out_len !== want.out_len) begin
               $display("%0t: out_len expected %h, got %h", $time, want.out_len,
                        got.out_len);
               mismatch_count++;
            end
            if (got.out_last !== want.out_last) begin
               $display("%0t: out_last expected %b, got %b", $time, want.out_last,
                        got.out_last);
               mismatch_count++;
            end
            if (got.out_count !== want.out_count) begin
               $display("%0t: out_count expected %0d, got %0d", $time, want.out_count,
                        got.out_count);
               mismatch_count++;
            end
            if (got.overrun !== want.overrun) begin
               $display("%0t: overrun expected %b, got %b", $time, want.overrun,
                        got.overrun);
               mismatch_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Stimulus: reset, the directed rows with no idling, then random requests
   // through four pressure phases, then a drain.
   initial begin
      int req_no;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_descriptor(directed_rows[i].d, directed_rows[i].chk, directed_rows[i].exp);
      sent_beats = 0;
      req_no     = 0;
      while (sent_beats < RANDOM_BEATS) begin
         unique case (sent_beats * 4 / RANDOM_BEATS)
            0: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            1: begin
               sender_idle_pct = 70;
               stall_pct       = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct       = 70;
            end
            default: begin
               sender_idle_pct = 33;
               stall_pct       = 33;
            end
         endcase
         run_request(req_no);
         req_no++;
      end
      req_tvalid <= 1'b0;
      while (pending_slices.size() != 0)
         @(posedge clock);
      // Keep clocking after the drain to catch stray beats.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sgl_range_slicer_top_test passed");
      end else begin
         $display("sgl_range_slicer_top_test failed");
      end
      $finish;
   end

   // Watchdog: stops the run as failed if the stimulus never finishes.
   initial begin
      #4_800_000;
      $display("sgl_range_slicer_top_test failed");
      $finish;
   end

endmodule
